[hdl/ebb_pkg.sv]
// ----------------------------------------------------------------------------
// ebb_pkg - shared types and constants of the 3x3 box blur
// Register indexes, item codes, the front-to-back operation record, the
// front sequencer states and the reciprocal table used for the mean.
// ----------------------------------------------------------------------------
package ebb_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 4;
	localparam int DIM_RESET = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// operation queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// mean arithmetic: sum of up to 9 pixels, count 1..9
	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int NUM_W       = SUM_W + 1;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int PROD_W      = NUM_W + RECIP_W;

	typedef enum logic [1:0] {
		FE_PIXELS,
		FE_PRIME,
		FE_FLUSH
	} fe_state_t;

	// One column of the window plus what the back does with it.
	typedef struct packed {
		logic             top_en;     // upper row lies inside the image
		logic             bottom_en;  // incoming row takes part
		logic             left_en;    // oldest window column takes part
		logic             right_en;   // this column takes part
		logic             first_en;   // first result is produced
		logic             second_en;  // second result (last column)
		logic             done;       // last pixel of the frame
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] middle;
		logic [PIX_W-1:0] pix;
	} op_t;

	// ceil(2^18 / (2*n)); exact quotient for numerators below 2^13
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1:    r = RECIP_W'(131072);
			4'd2:    r = RECIP_W'(65536);
			4'd3:    r = RECIP_W'(43691);
			4'd4:    r = RECIP_W'(32768);
			4'd5:    r = RECIP_W'(26215);
			4'd6:    r = RECIP_W'(21846);
			4'd7:    r = RECIP_W'(18725);
			4'd8:    r = RECIP_W'(16384);
			4'd9:    r = RECIP_W'(14564);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/ebb_queue.sv]
// ----------------------------------------------------------------------------
// ebb_queue - operation queue between front and back
// Small register FIFO; the front reserves room before it issues a read.
// ----------------------------------------------------------------------------
module ebb_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  ebb_pkg::op_t              push_op,
	input  logic                      pop,
	output ebb_pkg::op_t              head,
	output logic                      head_valid,
	output logic [ebb_pkg::QCNT_W-1:0] count
);

	ebb_pkg::op_t                 mem_q [ebb_pkg::QDEPTH];
	logic [ebb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ebb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ebb_pkg::QCNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ebb_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ebb_pkg::QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + ebb_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - ebb_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < ebb_pkg::QCNT_W'(ebb_pkg::QDEPTH) || pop))
		else $error("operation queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("operation queue underflow");

endmodule

[hdl/ebb_front.sv]
// ----------------------------------------------------------------------------
// ebb_front - item intake, position tracking and line stores
// Accepts pixel and flush transactions, keeps row/column/flush positions,
// reads and updates the two line stores and queues one operation per
// useful item for the back, plus one priming operation before the flush run.
// ----------------------------------------------------------------------------
module ebb_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [ebb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ebb_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [ebb_pkg::PIX_W-1:0]     pixel_in,
	input  logic [ebb_pkg::QCNT_W-1:0]    q_count,
	output logic                          push,
	output ebb_pkg::op_t                  push_op
);

	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CW0   = (AW + 1 > ebb_pkg::CFG_W) ? AW + 1 : ebb_pkg::CFG_W;
	localparam int CW    = (HW + 1 > CW0) ? HW + 1 : CW0;
	localparam int W_RST = (ebb_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : ebb_pkg::DIM_RESET;
	localparam int H_RST = (ebb_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : ebb_pkg::DIM_RESET;

	logic [ebb_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [ebb_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

	ebb_pkg::fe_state_t state_q, state_d;
	logic [CW-1:0] width_q, height_q;
	logic [AW-1:0] col_q, col_d;
	logic [HW-1:0] row_q, row_d;
	logic [AW-1:0] flush_pos_q, flush_pos_d;

	logic [CW-1:0] cfg_ext, w_clamped, h_clamped;
	logic          cfg_hit;

	logic [CW-1:0] col_next, row_next, flush_next;
	logic          last_col, last_row;
	logic          room, accept, is_pix;

	logic          issue, mid_we, iss_wr;
	logic [AW-1:0] rd_addr;
	ebb_pkg::op_t  iss_op;

	logic                      v_s1, wr_s1, byp_s1;
	logic [AW-1:0]             addr_s1;
	ebb_pkg::op_t              op_s1;
	logic [ebb_pkg::PIX_W-1:0] byp_data_s1;
	logic [ebb_pkg::PIX_W-1:0] up_rd_q, mid_rd_q;
	logic [ebb_pkg::QCNT_W:0]  used;

	// register writes clamp into 1..MAX
	assign cfg_ext = CW'(cfg_data);
	always_comb begin
		priority if (cfg_ext == '0) begin
			w_clamped = CW'(1);
		end else if (cfg_ext > CW'(MAX_WIDTH)) begin
			w_clamped = CW'(MAX_WIDTH);
		end else begin
			w_clamped = cfg_ext;
		end
		priority if (cfg_ext == '0) begin
			h_clamped = CW'(1);
		end else if (cfg_ext > CW'(MAX_HEIGHT)) begin
			h_clamped = CW'(MAX_HEIGHT);
		end else begin
			h_clamped = cfg_ext;
		end
	end
	assign cfg_hit = cfg_valid &&
		(cfg_index == ebb_pkg::REG_WIDTH || cfg_index == ebb_pkg::REG_HEIGHT);

	assign col_next   = CW'(col_q) + CW'(1);
	assign row_next   = CW'(row_q) + CW'(1);
	assign flush_next = CW'(flush_pos_q) + CW'(1);
	assign last_col   = (col_next >= width_q);
	assign last_row   = (row_next >= height_q);

	// room for the queued ops plus the one still in the read stage
	assign used     = {1'b0, q_count} + (ebb_pkg::QCNT_W + 1)'(v_s1);
	assign room     = (used < (ebb_pkg::QCNT_W + 1)'(ebb_pkg::QDEPTH));
	assign in_stall = (state_q == ebb_pkg::FE_PRIME) || !room;
	assign accept   = in_valid && !in_stall;
	assign is_pix   = (kind == ebb_pkg::KIND_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ebb_pkg::FE_PIXELS;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		col_d       = col_q;
		row_d       = row_q;
		flush_pos_d = flush_pos_q;
		issue       = 1'b0;
		mid_we      = 1'b0;
		iss_wr      = 1'b0;
		rd_addr     = col_q;
		iss_op      = '0;
		unique case (state_q)
			ebb_pkg::FE_PIXELS: begin
				if (accept && is_pix) begin
					issue            = 1'b1;
					mid_we           = 1'b1;
					iss_wr           = 1'b1;
					iss_op.top_en    = (CW'(row_q) >= CW'(2));
					iss_op.bottom_en = 1'b1;
					iss_op.left_en   = (CW'(col_q) >= CW'(2));
					iss_op.right_en  = 1'b1;
					iss_op.first_en  = (row_q != '0) && (col_q != '0);
					iss_op.second_en = (row_q != '0) && last_col;
					iss_op.pix       = pixel_in;
					if (last_col) begin
						col_d = '0;
						if (last_row) begin
							row_d   = '0;
							state_d = ebb_pkg::FE_PRIME;
						end else begin
							row_d = row_next[HW-1:0];
						end
					end else begin
						col_d = col_next[AW-1:0];
					end
				end
			end
			ebb_pkg::FE_PRIME: begin
				// load column 0 of the last row into the back's window
				if (room) begin
					issue       = 1'b1;
					rd_addr     = '0;
					flush_pos_d = '0;
					state_d     = ebb_pkg::FE_FLUSH;
				end
			end
			ebb_pkg::FE_FLUSH: begin
				if (accept && !is_pix) begin
					issue           = 1'b1;
					rd_addr         = flush_next[AW-1:0];
					iss_op.top_en   = (height_q != CW'(1));
					iss_op.left_en  = (flush_pos_q != '0);
					iss_op.right_en = (flush_next < width_q);
					iss_op.first_en = 1'b1;
					iss_op.done     = (flush_next >= width_q);
					if (flush_next >= width_q) begin
						flush_pos_d = '0;
						state_d     = ebb_pkg::FE_PIXELS;
					end else begin
						flush_pos_d = flush_next[AW-1:0];
					end
				end
			end
		endcase
		if (cfg_hit) begin
			state_d     = ebb_pkg::FE_PIXELS;
			col_d       = '0;
			row_d       = '0;
			flush_pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CW'(W_RST);
			height_q    <= CW'(H_RST);
			col_q       <= '0;
			row_q       <= '0;
			flush_pos_q <= '0;
			v_s1        <= 1'b0;
			byp_s1      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == ebb_pkg::REG_WIDTH) begin
				width_q <= w_clamped;
			end
			if (cfg_valid && cfg_index == ebb_pkg::REG_HEIGHT) begin
				height_q <= h_clamped;
			end
			col_q       <= col_d;
			row_q       <= row_d;
			flush_pos_q <= flush_pos_d;
			v_s1        <= issue;
			// upper row write of the previous op lands this cycle: forward it
			byp_s1      <= issue && v_s1 && wr_s1 && (rd_addr == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1   <= iss_op;
			wr_s1   <= iss_wr;
			addr_s1 <= rd_addr;
		end
		byp_data_s1 <= mid_rd_q;
	end

	// line stores: read both at issue, middle takes the new pixel at once,
	// upper takes the old middle value in the following cycle
	always_ff @(posedge clk) begin
		if (issue) begin
			up_rd_q  <= upper_mem[rd_addr];
			mid_rd_q <= middle_mem[rd_addr];
		end
		if (mid_we) begin
			middle_mem[rd_addr] <= pixel_in;
		end
		if (v_s1 && wr_s1) begin
			upper_mem[addr_s1] <= mid_rd_q;
		end
	end

	assign push = v_s1;
	always_comb begin
		push_op        = op_s1;
		push_op.upper  = byp_s1 ? byp_data_s1 : up_rd_q;
		push_op.middle = mid_rd_q;
	end

endmodule

[hdl/ebb_back.sv]
// ----------------------------------------------------------------------------
// ebb_back - window, neighborhood sum and rounded mean
// Pops operations, produces zero to two results each, sums the in-image
// neighbors, divides by reciprocal multiply and holds the output register.
// ----------------------------------------------------------------------------
module ebb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ebb_pkg::op_t              head,
	input  logic                      head_valid,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ebb_pkg::PIX_W-1:0] blurred,
	output logic                      last_of_run,
	output logic                      frame_done
);

	logic [ebb_pkg::PIX_W-1:0] win_old_q [3];
	logic [ebb_pkg::PIX_W-1:0] win_cur_q [3];
	logic                      sub_q, sub_d;
	logic                      en;

	logic res_v, sel_left, sel_mid, sel_right, res_last, res_done;
	logic [ebb_pkg::SUM_W-1:0] sum_old, sum_cur, sum_new, res_sum;
	logic [ebb_pkg::CNT_W-1:0] n_rows, n_cols, res_cnt;

	logic                      s1_v, s1_last, s1_done;
	logic [ebb_pkg::SUM_W-1:0] s1_sum;
	logic [ebb_pkg::CNT_W-1:0] s1_cnt;

	logic [ebb_pkg::NUM_W-1:0]  num;
	logic [ebb_pkg::PROD_W-1:0] prod;

	logic                      out_v_q, last_q, done_q;
	logic [ebb_pkg::PIX_W-1:0] mean_q;

	function automatic logic [ebb_pkg::SUM_W-1:0] col_sum(
		input logic [ebb_pkg::PIX_W-1:0] t,
		input logic [ebb_pkg::PIX_W-1:0] m,
		input logic [ebb_pkg::PIX_W-1:0] b,
		input logic                      t_en,
		input logic                      b_en
	);
		logic [ebb_pkg::SUM_W-1:0] s;
		s = ebb_pkg::SUM_W'(t_en ? t : '0) + ebb_pkg::SUM_W'(m)
			+ ebb_pkg::SUM_W'(b_en ? b : '0);
		return s;
	endfunction

	assign en = !out_v_q || !out_stall;

	// result sequencing over the queue head
	always_comb begin
		res_v     = 1'b0;
		sel_left  = 1'b0;
		sel_mid   = 1'b0;
		sel_right = 1'b0;
		res_last  = 1'b0;
		res_done  = 1'b0;
		pop       = 1'b0;
		sub_d     = sub_q;
		if (en && head_valid) begin
			priority if (!sub_q && head.first_en) begin
				res_v     = 1'b1;
				sel_left  = head.left_en;
				sel_mid   = 1'b1;
				sel_right = head.right_en;
				res_last  = !head.second_en;
				res_done  = head.done;
				if (head.second_en) begin
					sub_d = 1'b1;
				end else begin
					pop = 1'b1;
				end
			end else begin
				if (head.second_en) begin
					res_v     = 1'b1;
					sel_mid   = head.first_en;
					sel_right = 1'b1;
					res_last  = 1'b1;
				end
				pop   = 1'b1;
				sub_d = 1'b0;
			end
		end
	end

	assign sum_old = col_sum(win_old_q[0], win_old_q[1], win_old_q[2],
		head.top_en, head.bottom_en);
	assign sum_cur = col_sum(win_cur_q[0], win_cur_q[1], win_cur_q[2],
		head.top_en, head.bottom_en);
	assign sum_new = col_sum(head.upper, head.middle, head.pix,
		head.top_en, head.bottom_en);

	assign res_sum = (sel_left ? sum_old : '0) + (sel_mid ? sum_cur : '0)
		+ (sel_right ? sum_new : '0);
	assign n_rows  = ebb_pkg::CNT_W'(1) + ebb_pkg::CNT_W'(head.top_en)
		+ ebb_pkg::CNT_W'(head.bottom_en);
	assign n_cols  = ebb_pkg::CNT_W'(sel_left) + ebb_pkg::CNT_W'(sel_mid)
		+ ebb_pkg::CNT_W'(sel_right);
	assign res_cnt = n_rows * n_cols;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q   <= 1'b0;
			s1_v    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				win_old_q[i] <= '0;
				win_cur_q[i] <= '0;
			end
		end else begin
			sub_q <= sub_d;
			if (pop) begin
				win_old_q    <= win_cur_q;
				win_cur_q[0] <= head.upper;
				win_cur_q[1] <= head.middle;
				win_cur_q[2] <= head.pix;
			end
			if (en) begin
				s1_v    <= res_v;
				out_v_q <= s1_v;
			end
		end
	end

	// round half up: floor((2*sum + n) / (2*n))
	assign num  = {s1_sum, 1'b0} + ebb_pkg::NUM_W'(s1_cnt);
	assign prod = ebb_pkg::PROD_W'(num) * ebb_pkg::PROD_W'(ebb_pkg::recip(s1_cnt));

	always_ff @(posedge clk) begin
		if (en) begin
			s1_sum  <= res_sum;
			s1_cnt  <= res_cnt;
			s1_last <= res_last;
			s1_done <= res_done;
			mean_q  <= prod[ebb_pkg::RECIP_SHIFT +: ebb_pkg::PIX_W];
			last_q  <= s1_last;
			done_q  <= s1_done;
		end
	end

	assign out_valid   = out_v_q;
	assign blurred     = mean_q;
	assign last_of_run = last_q;
	assign frame_done  = done_q;

	a_second_held: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (head_valid && head.second_en))
		else $error("second result pending without a two-result op at the head");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v |-> (s1_cnt != '0 && s1_cnt <= ebb_pkg::CNT_W'(9)))
		else $error("neighbor count out of 1..9");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v && res_done) |-> (res_last && pop))
		else $error("frame end result is not the last of its op");

endmodule

[hdl/edge_normalized_box_blur_3x3.sv]
// ----------------------------------------------------------------------------
// edge_normalized_box_blur_3x3 - streaming 3x3 mean filter, one channel
// Top level: front (intake, positions, line stores), operation queue and
// back (window, sum, rounded mean, output register).
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per input transaction, and each comes
// out as the half-up rounded mean of the neighbors of its 3x3 window that lie
// inside the image (divisor 1..9), so edges and corners are not darkened.
// Output lags by one row and one column: the pixel at (r, c) releases the
// center (r-1, c-1), and at the last column also (r-1, c). After the last
// pixel of a frame send image_width flush transactions (kind = 1); each
// returns one pixel of the last row and the final one raises frame_done.
// Flushes sent while pixels are expected, and pixels sent while flushes are
// expected, are accepted and dropped. last_of_run marks the last result of
// its input transaction. A register write restarts the frame.
// Rate: the front takes one transaction per cycle; the back produces one
// result per cycle while the output is not stalled (the last column gives
// two results), and the front stalls once the four-entry operation queue,
// counting the op in its read stage, is full. Entering the flush phase
// first loads column 0 of the last row while input stalls. An input
// transaction reaches its first result through the line store read, the
// queue, the neighborhood sum and the reciprocal multiply into the output register.
// The register port is always ready; write only while the block is idle.
module edge_normalized_box_blur_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ebb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ebb_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [ebb_pkg::PIX_W-1:0]     pixel_in,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ebb_pkg::PIX_W-1:0]     blurred,
	output logic                          last_of_run,
	output logic                          frame_done
);

	// front -> queue
	logic         push;
	ebb_pkg::op_t push_op;

	// queue -> back
	ebb_pkg::op_t                   head;
	logic                           head_valid;
	logic                           pop;
	logic [ebb_pkg::QCNT_W-1:0]     q_count;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	ebb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.pixel_in  (pixel_in),
		.q_count   (q_count),
		.push      (push),
		.push_op   (push_op)
	);

	// decouples intake from result delivery
	ebb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (q_count)
	);

	ebb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.blurred     (blurred),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

endmodule

[test/edge_normalized_box_blur_3x3_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_normalized_box_blur_3x3_test - self-checking bench for the 3x3 blur
// Streams frames of many sizes through the filter under random handshake
// pressure. A scoreboard class mirrors the filter and checks every pixel.
// ----------------------------------------------------------------------------
module edge_normalized_box_blur_3x3_test;

	localparam int PIX_W     = ebb_pkg::PIX_W;
	localparam int CFG_W     = ebb_pkg::CFG_W;
	localparam int CFG_IDX_W = ebb_pkg::CFG_IDX_W;

	localparam int MAX_DIM       = 1024;
	localparam int SHOWN_ERRORS  = 10;
	localparam int SETTLE_CYCLES = 16;   // covers the pipeline, the 4-deep op queue and flush priming
	localparam int RANDOM_ITEMS  = 920;

	// A write here lands on no register and must leave the frame running.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

	// 3x3 directed image, row major, first pixel in the low byte:
	// a bright top row, a dark center, and a dark bottom row ending in 1.
	localparam logic [9*PIX_W-1:0] CORNER_IMG = {
		8'd1,   8'd0, 8'd0,
		8'd255, 8'd0, 8'd255,
		8'd255, 8'd255, 8'd255
	};

	typedef enum int unsigned {
		CALM,
		SENDER_GAPS,
		RECEIVER_STALLS,
		BOTH_IDLE
	} pressure_t;

	typedef struct {
		logic [PIX_W-1:0] mean;
		logic             last;
		logic             done;
	} blur_px_t;

	// ------------------------------------------------------------------------
	// Shadow of the filter: line stores, 3x3 window, raster position and the
	// list of output pixels that the accepted transactions have produced.
	// ------------------------------------------------------------------------
	class blur_shadow;
		bit [PIX_W-1:0] upper_row [MAX_DIM];
		bit [PIX_W-1:0] middle_row [MAX_DIM];
		bit [PIX_W-1:0] left_col [3];   // index 0 upper, 1 middle, 2 incoming row
		bit [PIX_W-1:0] mid_col [3];
		int unsigned    row_pos;
		int unsigned    col_pos;
		int unsigned    flush_pos;      // 0 while pixels are due, else 1 + flush column
		int unsigned    width = MAX_DIM;
		int unsigned    height = MAX_DIM;
		blur_px_t       pending_means [$];
		int unsigned    mismatches;

		function int unsigned clamp_dim(logic [CFG_W-1:0] v);
			if (v < 1)
				return 1;
			if (v > MAX_DIM)
				return MAX_DIM;
			return v;
		endfunction

		// A width or height write restarts the frame; line stores keep their data.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == ebb_pkg::REG_WIDTH)
				width = clamp_dim(v);
			else if (idx == ebb_pkg::REG_HEIGHT)
				height = clamp_dim(v);
			else
				return;
			row_pos = 0;
			col_pos = 0;
			flush_pos = 0;
		endfunction

		function void add_col(bit [PIX_W-1:0] v [3], bit [2:0] rows,
				inout int unsigned sum, inout int unsigned cnt);
			for (int i = 0; i < 3; i++)
				if (rows[i]) begin
					sum += v[i];
					cnt++;
				end
		endfunction

		// half-up rounding: floor((2*sum + cnt) / (2*cnt))
		function void push_mean(int unsigned sum, int unsigned cnt, bit last, bit done);
			blur_px_t px;
			px.mean = PIX_W'((2 * sum + cnt) / (2 * cnt));
			px.last = last;
			px.done = done;
			pending_means.push_back(px);
		endfunction

		function void take_item(logic k, logic [PIX_W-1:0] p);
			int unsigned    c;
			int unsigned    lo;
			int unsigned    sum;
			int unsigned    cnt;
			bit [2:0]       rows;
			bit [PIX_W-1:0] col [3];
			bit             at_end;
			if (k == ebb_pkg::KIND_FLUSH) begin
				if (flush_pos == 0)
					return;   // no frame finished yet: dropped
				c = flush_pos - 1;
				// last row: the row above only exists for two or more rows
				rows = {1'b0, 1'b1, height >= 2};
				sum = 0;
				cnt = 0;
				lo = (c == 0) ? 0 : c - 1;
				for (int unsigned x = lo; x <= c + 1 && x < width; x++) begin
					col = '{upper_row[x], middle_row[x], '0};
					add_col(col, rows, sum, cnt);
				end
				at_end = (c + 1 >= width);
				push_mean(sum, cnt, 1'b1, at_end);
				flush_pos = at_end ? 0 : flush_pos + 1;
				return;
			end
			if (flush_pos != 0)
				return;   // flush pending: pixel dropped
			c = col_pos;
			rows = {2'b11, row_pos >= 2};
			col = '{upper_row[c], middle_row[c], p};
			if (row_pos >= 1) begin
				at_end = (c + 1 >= width);
				if (c >= 1) begin
					sum = 0;
					cnt = 0;
					if (c >= 2)
						add_col(left_col, rows, sum, cnt);
					add_col(mid_col, rows, sum, cnt);
					add_col(col, rows, sum, cnt);
					push_mean(sum, cnt, !at_end, 1'b0);
				end
				// last column also releases its own center
				if (at_end) begin
					sum = 0;
					cnt = 0;
					if (c >= 1)
						add_col(mid_col, rows, sum, cnt);
					add_col(col, rows, sum, cnt);
					push_mean(sum, cnt, 1'b1, 1'b0);
				end
			end
			left_col = mid_col;
			mid_col = col;
			upper_row[c] = middle_row[c];
			middle_row[c] = p;
			if (c + 1 >= width) begin
				col_pos = 0;
				if (row_pos + 1 >= height) begin
					row_pos = 0;
					flush_pos = 1;
				end else begin
					row_pos++;
				end
			end else begin
				col_pos++;
			end
		endfunction

		function void check_pixel(logic [PIX_W-1:0] mean, logic last, logic done);
			blur_px_t want;
			if (pending_means.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("unexpected result: blurred %0d last_of_run %b frame_done %b",
						mean, last, done);
				return;
			end
			want = pending_means.pop_front();
			if (want.mean !== mean || want.last !== last || want.done !== done) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("mismatch: blurred %0d/%0d last_of_run %b/%b frame_done %b/%b (exp/got)",
						want.mean, mean, want.last, last, want.done, done);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 kind;
	logic [PIX_W-1:0]     pixel_in;
	logic                 out_valid;
	logic                 out_stall;
	logic [PIX_W-1:0]     blurred;
	logic                 last_of_run;
	logic                 frame_done;

	blur_shadow  shadow;
	int unsigned idle_pct;    // chance per cycle that the sender holds back
	int unsigned stall_pct;   // chance per cycle that the receiver stalls
	int unsigned items_sent;

	edge_normalized_box_blur_3x3 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.pixel_in    (pixel_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.blurred     (blurred),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#(20_000_000);
		$display("FAIL edge_normalized_box_blur_3x3");
		$finish;
	end

	// Output side: a transaction completes on an edge with valid high and
	// stall low, both sampled as they stood before the edge. The stall for
	// the next cycle is drawn here as well.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_pixel(blurred, last_of_run, frame_done);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic set_pressure(pressure_t mode);
		case (mode)
			CALM: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			SENDER_GAPS: begin
				idle_pct = 48;
				stall_pct = 0;
			end
			RECEIVER_STALLS: begin
				idle_pct = 0;
				stall_pct = 48;
			end
			default: begin
				idle_pct = 6;
				stall_pct = 6;
			end
		endcase
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// One input transaction. Valid stays high into the next call unless that
	// call opens a gap, so back-to-back items need a single assignment.
	task automatic send_item(logic k, logic [PIX_W-1:0] p);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		pixel_in <= p;
		do
			@(posedge clk);
		while (in_stall);
		shadow.take_item(k, p);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		shadow.write_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every predicted pixel is out, then let the pipe run dry
	// (rows 0 and dropped items produce nothing but may still be in flight).
	task automatic settle();
		in_valid <= 1'b0;
		while (shadow.pending_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Raster pixels then the flush run; cut >= 0 abandons the frame at that
	// transaction. Noise inserts items of the wrong kind, which get dropped.
	task automatic run_frame(int unsigned w, int unsigned h, bit noisy, int cut);
		int total;
		int n_pix;
		total = w * h + w;
		n_pix = w * h;
		for (int i = 0; i < total; i++) begin
			if (i == cut)
				break;
			if (noisy && $urandom_range(99) < 3)
				send_item(i < n_pix ? ebb_pkg::KIND_FLUSH : ebb_pkg::KIND_PIXEL,
					PIX_W'($urandom));
			send_item(i < n_pix ? ebb_pkg::KIND_PIXEL : ebb_pkg::KIND_FLUSH, rand_pixel());
			items_sent++;
		end
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int          cut;
		bit          clean;
		shadow = new;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= ebb_pkg::REG_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= ebb_pkg::KIND_PIXEL;
		pixel_in <= '0;
		out_stall <= 1'b0;
		set_pressure(CALM);
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame: saturated and dark pixels for the rounding extremes,
		// every edge and corner divisor, plus a stray flush before the
		// frame and a stray pixel before its flush run (both dropped).
		write_reg(ebb_pkg::REG_WIDTH, 3);
		write_reg(ebb_pkg::REG_HEIGHT, 3);
		send_item(ebb_pkg::KIND_FLUSH, 8'hA5);
		for (int i = 0; i < 9; i++)
			send_item(ebb_pkg::KIND_PIXEL, CORNER_IMG[PIX_W*i +: PIX_W]);
		send_item(ebb_pkg::KIND_PIXEL, 8'h5A);
		repeat (3)
			send_item(ebb_pkg::KIND_FLUSH, 8'h00);
		settle();

		// Width 0 acts as one column. A write to an unused index in the
		// middle of the frame must not restart it.
		write_reg(ebb_pkg::REG_WIDTH, 0);
		write_reg(ebb_pkg::REG_HEIGHT, 2);
		send_item(ebb_pkg::KIND_PIXEL, 8'hFF);
		settle();
		write_reg(REG_UNUSED, '1);
		send_item(ebb_pkg::KIND_PIXEL, 8'h00);
		send_item(ebb_pkg::KIND_FLUSH, 8'hFF);
		settle();

		// Height 0 acts as one row: a single pixel frame is its own mean.
		write_reg(ebb_pkg::REG_HEIGHT, 0);
		send_item(ebb_pkg::KIND_PIXEL, 8'h80);
		send_item(ebb_pkg::KIND_FLUSH, 8'h00);
		settle();

		// One row, two columns: only the flush run gives results.
		write_reg(ebb_pkg::REG_WIDTH, 2);
		send_item(ebb_pkg::KIND_PIXEL, 8'd7);
		send_item(ebb_pkg::KIND_PIXEL, 8'd8);
		send_item(ebb_pkg::KIND_FLUSH, 8'h00);
		send_item(ebb_pkg::KIND_FLUSH, 8'h00);
		settle();

		// Random frames, mostly small. Some are abandoned part way (during
		// pixels or the flush run) and restarted by the next register write;
		// clean ones may be followed by a frame with the same setting.
		items_sent = 0;
		clean = 1'b0;
		while (items_sent < RANDOM_ITEMS) begin
			set_pressure(pressure_t'($urandom_range(3)));
			if (!clean || $urandom_range(3) != 0) begin
				case ($urandom_range(19))
					0:             w = $urandom_range(100, 41);
					1, 2, 3, 4, 5: w = $urandom_range(40, 11);
					default:       w = $urandom_range(10, 1);
				endcase
				h = ($urandom_range(19) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
				settle();
				if ($urandom_range(19) == 0)
					write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1,
						ebb_pkg::REG_HEIGHT + 1)), CFG_W'($urandom));
				if ($urandom_range(1)) begin
					write_reg(ebb_pkg::REG_WIDTH, CFG_W'(w));
					write_reg(ebb_pkg::REG_HEIGHT, CFG_W'(h));
				end else begin
					write_reg(ebb_pkg::REG_HEIGHT, CFG_W'(h));
					write_reg(ebb_pkg::REG_WIDTH, CFG_W'(w));
				end
			end
			cut = ($urandom_range(99) < 15) ? $urandom_range(w * h + w - 1) : -1;
			run_frame(w, h, 1'b1, cut);
			clean = (cut < 0);
		end
		settle();

		if (shadow.mismatches == 0 && shadow.pending_means.size() == 0)
			$display("PASS edge_normalized_box_blur_3x3");
		else
			$display("FAIL edge_normalized_box_blur_3x3");
		$finish;
	end

endmodule
